// ===== hw/rtl/lavm_pkg.sv =====
`timescale 1ns / 1ps
package lavm_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int DW = 32;
    // normalized coefficients stay within +/- 2^FRACTION_BITS, plus headroom for rounding
    localparam int CW = FRACTION_BITS + 3;
    localparam int PW = CW + DW;
    localparam int SW = PW + 2;
    localparam int QW = FRACTION_BITS + 2;
    localparam int RW = DW + QW;
    localparam int NORM_BITS = 31;

    typedef logic signed [DW-1:0] t_data;
    typedef logic signed [CW-1:0] t_coef;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_wide;

    localparam t_data ONE  = t_data'(1) <<< FRACTION_BITS;
    localparam t_data DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_data DMIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic done;
        logic zero;
    } t_norm_stat;

    typedef struct packed {
        logic [2:0][DW-1:0] eye;
        logic [2:0][DW:0]   dir;
        logic [2:0][DW-1:0] up;
        logic               dzero;
    } t_item;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SCALE,
        N_SQ,
        N_SQRT,
        N_DIV,
        N_FIN
    } t_nstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORMF,
        B_CROSS,
        B_NORMS,
        B_UVEC,
        B_DOT,
        B_EMIT,
        B_IDENT
    } t_bstate;

    function automatic logic [1:0] inc3(logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    // divide by 2^FRACTION_BITS, half away from zero
    function automatic t_wide round_fb(t_wide x);
        logic [SW-1:0] mag;
        logic [SW-1:0] r;
        mag = x[SW-1] ? -x : x;
        r = (mag + (SW'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        return x[SW-1] ? -t_wide'(r) : t_wide'(r);
    endfunction

    function automatic t_data sat_val(t_wide x);
        if (x > t_wide'(DMAX)) begin
            return DMAX;
        end else if (x < t_wide'(DMIN)) begin
            return DMIN;
        end
        return t_data'(x);
    endfunction

    function automatic logic sat_hit(t_wide x);
        return (x > t_wide'(DMAX)) || (x < t_wide'(DMIN));
    endfunction

endpackage

// ===== hw/rtl/lavm_front.sv =====
`timescale 1ns / 1ps
module lavm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lavm_pkg::t_data  i_eye [3],
    input  lavm_pkg::t_data  i_target [3],
    input  lavm_pkg::t_data  i_up [3],
    input  logic             i_pop,
    output logic             o_busy,
    output logic             o_head_vld,
    output lavm_pkg::t_item  o_head
);
    import lavm_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      item;
    logic       push;

    always_comb begin
        item = '0;
        for (int k = 0; k < 3; k++) begin
            item.eye[k] = i_eye[k];
            item.up[k]  = i_up[k];
            item.dir[k] = (DW+1)'(i_target[k]) - (DW+1)'(i_eye[k]);
        end
        // target on top of eye: no view direction
        item.dzero = (item.dir[0] == '0) && (item.dir[1] == '0) && (item.dir[2] == '0);
    end

    assign o_busy     = (r_cnt == 2'd2);
    assign push       = i_start && !o_busy;
    assign o_head_vld = (r_cnt != 2'd0);
    assign o_head     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

// ===== hw/rtl/lavm_norm.sv =====
`timescale 1ns / 1ps
module lavm_norm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  lavm_pkg::t_wide      i_vec [3],
    output lavm_pkg::t_norm_stat o_stat,
    output lavm_pkg::t_coef      o_res [3]
);
    import lavm_pkg::*;

    t_nstate                 r_state;
    t_nstate                 n_state;
    logic [SW-1:0]           r_m [3];
    logic [2:0]              r_neg;
    logic                    r_zero;
    logic [5:0]              r_cnt;
    logic [2*NORM_BITS-1:0]  r_prod;
    logic [63:0]             r_acc;
    logic [63:0]             r_rem;
    logic [63:0]             r_root;
    logic [63:0]             r_bit;
    logic [RW-1:0]           r_drem;
    logic [RW-1:0]           r_dden;
    logic [QW-1:0]           r_q;
    logic [1:0]              r_idx;
    t_coef                   r_res [3];

    logic [SW-1:0]           mx;
    logic [SW-1:0]           m_sel;
    logic [SW-1:0]           m_nxt;
    logic                    vec_zero;
    logic                    hi4;
    logic                    hi1;
    logic                    lo4;
    logic                    lo1;
    logic [63:0]             trial;
    logic                    sq_ge;
    logic [63:0]             root_nxt;
    logic                    dv_ge;
    logic [QW-1:0]           q_nxt;
    logic [CW-1:0]           q_ext;

    function automatic logic [SW-1:0] pick_m(logic [SW-1:0] a0, logic [SW-1:0] a1,
                                              logic [SW-1:0] a2, logic [1:0] idx);
        case (idx)
            2'd1:    return a1;
            2'd2:    return a2;
            default: return a0;
        endcase
    endfunction

    // rounded numerator of the per-axis divide
    function automatic logic [RW-1:0] num_of(logic [SW-1:0] m, logic [31:0] len);
        return (RW'(m[NORM_BITS-1:0]) << FRACTION_BITS) + RW'(len >> 1);
    endfunction

    always_comb begin
        mx = r_m[0];
        if (r_m[1] > mx) begin
            mx = r_m[1];
        end
        if (r_m[2] > mx) begin
            mx = r_m[2];
        end
    end

    assign vec_zero = (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);
    assign hi4 = |mx[SW-1:NORM_BITS+4];
    assign hi1 = |mx[SW-1:NORM_BITS];
    assign lo4 = ~|mx[SW-1:NORM_BITS-5];
    assign lo1 = !mx[NORM_BITS-1];

    assign m_sel    = pick_m(r_m[0], r_m[1], r_m[2], r_cnt[1:0]);
    assign m_nxt    = pick_m(r_m[0], r_m[1], r_m[2], inc3(r_idx));
    assign trial    = r_root + r_bit;
    assign sq_ge    = (r_rem >= trial);
    assign root_nxt = sq_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
    assign dv_ge    = (r_drem >= r_dden);
    assign q_nxt    = {r_q[QW-2:0], dv_ge};
    assign q_ext    = {1'b0, q_nxt};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    n_state = vec_zero ? N_FIN : N_SCALE;
                end
            end
            N_SCALE: begin
                if (!hi1 && !lo1) begin
                    n_state = N_SQ;
                end
            end
            N_SQ: begin
                if (r_cnt == 6'd3) begin
                    n_state = N_SQRT;
                end
            end
            N_SQRT: begin
                if (r_cnt == 6'd31) begin
                    n_state = N_DIV;
                end
            end
            N_DIV: begin
                if ((r_cnt == 6'(QW - 1)) && (r_idx == 2'd2)) begin
                    n_state = N_FIN;
                end
            end
            N_FIN: begin
                n_state = N_IDLE;
            end
            default: begin
                n_state = N_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_stat.done = (r_state == N_FIN);
        o_stat.zero = r_zero;
        for (int k = 0; k < 3; k++) begin
            o_res[k] = r_res[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    r_zero <= vec_zero;
                    r_acc  <= '0;
                    r_cnt  <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_m[k]   <= i_vec[k][SW-1] ? -i_vec[k] : i_vec[k];
                        r_neg[k] <= i_vec[k][SW-1];
                    end
                end
            end
            N_SCALE: begin
                // bring the largest magnitude into [2^30, 2^31)
                for (int k = 0; k < 3; k++) begin
                    if (hi4) begin
                        r_m[k] <= r_m[k] >> 4;
                    end else if (hi1) begin
                        r_m[k] <= r_m[k] >> 1;
                    end else if (lo4) begin
                        r_m[k] <= r_m[k] << 4;
                    end else if (lo1) begin
                        r_m[k] <= r_m[k] << 1;
                    end
                end
                r_cnt <= '0;
            end
            N_SQ: begin
                if (r_cnt != 6'd3) begin
                    r_prod <= (2*NORM_BITS)'(m_sel[NORM_BITS-1:0]) *
                              (2*NORM_BITS)'(m_sel[NORM_BITS-1:0]);
                end
                if (r_cnt != 6'd0) begin
                    r_acc <= r_acc + 64'(r_prod);
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd3) begin
                    r_rem  <= r_acc + 64'(r_prod);
                    r_root <= '0;
                    r_bit  <= 64'd1 << 62;
                    r_cnt  <= '0;
                end
            end
            N_SQRT: begin
                if (sq_ge) begin
                    r_rem <= r_rem - trial;
                end
                r_root <= root_nxt;
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_cnt  <= '0;
                    r_idx  <= 2'd0;
                    r_drem <= num_of(r_m[0], root_nxt[31:0]);
                    r_dden <= RW'(root_nxt[31:0]) << (QW - 1);
                end
            end
            N_DIV: begin
                if (dv_ge) begin
                    r_drem <= r_drem - r_dden;
                end
                r_dden <= r_dden >> 1;
                r_q    <= q_nxt;
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(QW - 1)) begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_idx == 2'(k)) begin
                            r_res[k] <= r_neg[k] ? -t_coef'(q_ext) : t_coef'(q_ext);
                        end
                    end
                    r_cnt  <= '0;
                    r_idx  <= inc3(r_idx);
                    r_drem <= num_of(m_nxt, r_root[31:0]);
                    r_dden <= RW'(r_root[31:0]) << (QW - 1);
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lavm_back.sv =====
`timescale 1ns / 1ps
module lavm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_vld,
    input  lavm_pkg::t_item i_head,
    output logic            o_pop,
    output logic            o_valid,
    output logic [1:0]      o_row_index,
    output lavm_pkg::t_data o_col_0,
    output lavm_pkg::t_data o_col_1,
    output lavm_pkg::t_data o_col_2,
    output lavm_pkg::t_data o_col_3,
    output logic            o_degenerate,
    output logic            o_saturated,
    output logic            o_last_row
);
    import lavm_pkg::*;

    t_bstate    r_state;
    t_bstate    n_state;
    t_data      r_eye [3];
    t_data      r_up [3];
    t_coef      r_f [3];
    t_coef      r_s [3];
    t_coef      r_u [3];
    t_wide      r_sum [3];
    t_data      r_t [3];
    logic       r_clip;
    logic [1:0] r_dst;
    logic [1:0] r_term;
    logic       r_issue_done;
    logic       r_pv;
    logic [1:0] r_pdst;
    logic       r_pfirst;
    logic       r_psub;
    t_prod      r_prod;
    logic [1:0] r_row;

    logic       r_ov;
    logic [1:0] r_orow;
    t_data      r_oc [4];
    logic       r_odeg;
    logic       r_osat;

    t_norm_stat nstat;
    t_coef      nres [3];
    t_wide      nvec [3];
    logic       norm_start;
    logic       mac_phase;
    logic       mac_done;
    logic       last_term;
    logic [1:0] i1;
    logic [1:0] i2;
    logic [1:0] ia;
    logic [1:0] ib;
    t_coef      mac_a;
    t_data      mac_b;
    logic       mac_sub;
    t_data      post_t [3];
    logic [2:0] post_c;
    t_data      row_c [4];
    logic       row_sat;

    function automatic t_coef pick_c(t_coef a0, t_coef a1, t_coef a2, logic [1:0] idx);
        case (idx)
            2'd1:    return a1;
            2'd2:    return a2;
            default: return a0;
        endcase
    endfunction

    function automatic t_data pick_d(t_data a0, t_data a1, t_data a2, logic [1:0] idx);
        case (idx)
            2'd1:    return a1;
            2'd2:    return a2;
            default: return a0;
        endcase
    endfunction

    lavm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec   (nvec),
        .o_stat  (nstat),
        .o_res   (nres)
    );

    assign mac_phase = (r_state == B_CROSS) || (r_state == B_UVEC) || (r_state == B_DOT);
    assign mac_done  = r_issue_done && !r_pv;
    assign last_term = (r_state == B_DOT) ? (r_term == 2'd2) : (r_term == 2'd1);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nvec[k] = (r_state == B_IDLE) ? t_wide'($signed(i_head.dir[k])) : r_sum[k];
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        i1      = inc3(r_dst);
        i2      = inc3(i1);
        ia      = (r_term == 2'd0) ? i1 : i2;
        ib      = (r_term == 2'd0) ? i2 : i1;
        mac_sub = (r_term != 2'd0);
        case (r_state)
            B_CROSS: begin
                mac_a = pick_c(r_f[0], r_f[1], r_f[2], ia);
                mac_b = pick_d(r_up[0], r_up[1], r_up[2], ib);
            end
            B_UVEC: begin
                mac_a = pick_c(r_s[0], r_s[1], r_s[2], ia);
                mac_b = t_data'(pick_c(r_f[0], r_f[1], r_f[2], ib));
            end
            default: begin
                mac_sub = 1'b0;
                case (r_dst)
                    2'd0:    mac_a = pick_c(r_s[0], r_s[1], r_s[2], r_term);
                    2'd1:    mac_a = pick_c(r_u[0], r_u[1], r_u[2], r_term);
                    default: mac_a = pick_c(r_f[0], r_f[1], r_f[2], r_term);
                endcase
                mac_b = pick_d(r_eye[0], r_eye[1], r_eye[2], r_term);
            end
        endcase
    end

    // translation column: -s.eye, -u.eye, f.eye
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            post_t[k] = sat_val((k < 2) ? -round_fb(r_sum[k]) : round_fb(r_sum[k]));
            post_c[k] = sat_hit((k < 2) ? -round_fb(r_sum[k]) : round_fb(r_sum[k]));
        end
    end

    always_comb begin
        row_sat = 1'b0;
        for (int j = 0; j < 4; j++) begin
            row_c[j] = (r_row == 2'(j)) ? ONE : '0;
        end
        if (r_state == B_EMIT) begin
            if (r_row == 2'd3) begin
                row_c[0] = r_t[0];
                row_c[1] = r_t[1];
                row_c[2] = r_t[2];
                row_c[3] = ONE;
                row_sat  = r_clip;
            end else begin
                row_c[0] = t_data'(pick_c(r_s[0], r_s[1], r_s[2], r_row));
                row_c[1] = t_data'(pick_c(r_u[0], r_u[1], r_u[2], r_row));
                row_c[2] = -t_data'(pick_c(r_f[0], r_f[1], r_f[2], r_row));
                row_c[3] = '0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_head_vld) begin
                    n_state = i_head.dzero ? B_IDENT : B_NORMF;
                end
            end
            B_NORMF: begin
                if (nstat.done) begin
                    n_state = nstat.zero ? B_IDENT : B_CROSS;
                end
            end
            B_CROSS: begin
                if (mac_done) begin
                    n_state = B_NORMS;
                end
            end
            B_NORMS: begin
                if (nstat.done) begin
                    n_state = nstat.zero ? B_IDENT : B_UVEC;
                end
            end
            B_UVEC: begin
                if (mac_done) begin
                    n_state = B_DOT;
                end
            end
            B_DOT: begin
                if (mac_done) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT, B_IDENT: begin
                if (r_row == 2'd3) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_pop      = (r_state == B_IDLE) && i_head_vld;
        norm_start = ((r_state == B_IDLE) && i_head_vld && !i_head.dzero) ||
                     ((r_state == B_CROSS) && mac_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_dst        <= 2'd0;
            r_term       <= 2'd0;
            r_issue_done <= 1'b0;
            r_pv         <= 1'b0;
            r_row        <= 2'd0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= mac_phase && !r_issue_done;
            if (!mac_phase || mac_done) begin
                r_dst        <= 2'd0;
                r_term       <= 2'd0;
                r_issue_done <= 1'b0;
            end else if (!r_issue_done) begin
                if (last_term) begin
                    r_term <= 2'd0;
                    if (r_dst == 2'd2) begin
                        r_issue_done <= 1'b1;
                    end else begin
                        r_dst <= r_dst + 2'd1;
                    end
                end else begin
                    r_term <= r_term + 2'd1;
                end
            end
            if ((r_state == B_EMIT) || (r_state == B_IDENT)) begin
                r_row <= r_row + 2'd1;
            end else begin
                r_row <= 2'd0;
            end
            r_ov <= (r_state == B_EMIT) || (r_state == B_IDENT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < 3; k++) begin
                r_eye[k] <= $signed(i_head.eye[k]);
                r_up[k]  <= $signed(i_head.up[k]);
            end
        end
        if ((r_state == B_NORMF) && nstat.done) begin
            for (int k = 0; k < 3; k++) begin
                r_f[k] <= nres[k];
            end
        end
        if ((r_state == B_NORMS) && nstat.done) begin
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= nres[k];
            end
        end
        if ((r_state == B_UVEC) && mac_done) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= t_coef'(round_fb(r_sum[k]));
            end
        end
        if ((r_state == B_DOT) && mac_done) begin
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= post_t[k];
            end
            r_clip <= |post_c;
        end
        if (mac_phase && !r_issue_done) begin
            r_prod   <= mac_a * mac_b;
            r_pdst   <= r_dst;
            r_pfirst <= (r_term == 2'd0);
            r_psub   <= mac_sub;
        end
        if (r_pv) begin
            for (int k = 0; k < 3; k++) begin
                if (r_pdst == 2'(k)) begin
                    if (r_psub) begin
                        r_sum[k] <= (r_pfirst ? t_wide'(0) : r_sum[k]) - t_wide'(r_prod);
                    end else begin
                        r_sum[k] <= (r_pfirst ? t_wide'(0) : r_sum[k]) + t_wide'(r_prod);
                    end
                end
            end
        end
        r_orow <= r_row;
        for (int j = 0; j < 4; j++) begin
            r_oc[j] <= row_c[j];
        end
        r_odeg <= (r_state == B_IDENT);
        r_osat <= row_sat;
    end

    assign o_valid      = r_ov;
    assign o_row_index  = r_orow;
    assign o_col_0      = r_oc[0];
    assign o_col_1      = r_oc[1];
    assign o_col_2      = r_oc[2];
    assign o_col_3      = r_oc[3];
    assign o_degenerate = r_odeg;
    assign o_saturated  = r_osat;
    assign o_last_row   = (r_orow == 2'd3);

endmodule

// ===== hw/rtl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// look-at view matrix, signed fixed point (Q16.16 by default)
// input channel: a camera item (eye, target, upward vectors) is taken at a rising
// edge with start high and busy low. busy rises only when the two-entry item queue
// in front of the compute engine is full, so two items can be handed over while
// an earlier one is still being worked on.
// result channel: four rows per item, row 0 to 3 on consecutive cycles, each
// marked by o_valid for exactly one cycle; o_last_row flags row 3. the receiver
// cannot stall, the rows simply go by.
// the engine works on one item at a time and takes the next one only after returning
// to idle; it makes two passes through the shared normalize unit (scaling, squares of
// the three components, a 32-step square root, three 18-step divides, a finish step),
// with multiply-accumulate work for the cross and dot products, four rows and an idle step.
// rows leave through an output register, in the cycle after they are formed.
// when a direction has zero length (target equal to eye, or a zero cross product)
// all four rows carry the identity with o_degenerate set.
// reset (synchronous, active low) empties the queue and returns the engine to idle;
// no result is pending afterwards.
module look_at_view_matrix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  lavm_pkg::t_data i_eye_x,
    input  lavm_pkg::t_data i_eye_y,
    input  lavm_pkg::t_data i_eye_z,
    input  lavm_pkg::t_data i_target_x,
    input  lavm_pkg::t_data i_target_y,
    input  lavm_pkg::t_data i_target_z,
    input  lavm_pkg::t_data i_upward_x,
    input  lavm_pkg::t_data i_upward_y,
    input  lavm_pkg::t_data i_upward_z,
    output logic            busy,
    output logic            o_valid,
    output logic [1:0]      o_row_index,
    output lavm_pkg::t_data o_col_0,
    output lavm_pkg::t_data o_col_1,
    output lavm_pkg::t_data o_col_2,
    output lavm_pkg::t_data o_col_3,
    output logic            o_degenerate,
    output logic            o_saturated,
    output logic            o_last_row
);
    import lavm_pkg::*;

    t_data eye [3];
    t_data target [3];
    t_data up [3];
    t_item head;
    logic  head_vld;
    logic  pop;

    assign eye[0]    = i_eye_x;
    assign eye[1]    = i_eye_y;
    assign eye[2]    = i_eye_z;
    assign target[0] = i_target_x;
    assign target[1] = i_target_y;
    assign target[2] = i_target_z;
    assign up[0]     = i_upward_x;
    assign up[1]     = i_upward_y;
    assign up[2]     = i_upward_z;

    lavm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_eye      (eye),
        .i_target   (target),
        .i_up       (up),
        .i_pop      (pop),
        .o_busy     (busy),
        .o_head_vld (head_vld),
        .o_head     (head)
    );

    lavm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_vld   (head_vld),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_row_index  (o_row_index),
        .o_col_0      (o_col_0),
        .o_col_1      (o_col_1),
        .o_col_2      (o_col_2),
        .o_col_3      (o_col_3),
        .o_degenerate (o_degenerate),
        .o_saturated  (o_saturated),
        .o_last_row   (o_last_row)
    );

    // rows of one item come out back to back
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_row |=> o_valid && (o_row_index == 2'($past(o_row_index) + 2'd1)))
        else $error("row sequence broken");

    // a matrix ends with a gap before the next one
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_row |=> !o_valid)
        else $error("row after last row");

    a_degen_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> !o_saturated)
        else $error("clip flagged on identity row");

    a_clip_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_last_row)
        else $error("clip flagged outside translation row");

endmodule

// ===== tb/sv/tb_look_at_view_matrix.sv =====
`timescale 1ns / 1ps
module tb_look_at_view_matrix;
    import lavm_pkg::*;

    typedef longint vec3_t [3];

    typedef struct packed {
        logic [1:0]      row;
        logic [3:0][31:0] col;
        logic            degen;
        logic            sat;
        logic            last;
    } matrix_row_t;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    t_data i_eye_x, i_eye_y, i_eye_z;
    t_data i_target_x, i_target_y, i_target_z;
    t_data i_upward_x, i_upward_y, i_upward_z;
    logic  busy;
    logic  o_valid;
    logic [1:0] o_row_index;
    t_data o_col_0, o_col_1, o_col_2, o_col_3;
    logic  o_degenerate, o_saturated, o_last_row;

    matrix_row_t expected_rows[$];
    int          error_count;
    int          idle_pct;
    int          quiet_cycles;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam t_data QMAX = 32'sh7fffffff;
    localparam t_data QMIN = 32'sh80000000;

    look_at_view_matrix u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_eye_x      (i_eye_x),
        .i_eye_y      (i_eye_y),
        .i_eye_z      (i_eye_z),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .i_target_z   (i_target_z),
        .i_upward_x   (i_upward_x),
        .i_upward_y   (i_upward_y),
        .i_upward_z   (i_upward_z),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_row_index  (o_row_index),
        .o_col_0      (o_col_0),
        .o_col_1      (o_col_1),
        .o_col_2      (o_col_2),
        .o_col_3      (o_col_3),
        .o_degenerate (o_degenerate),
        .o_saturated  (o_saturated),
        .o_last_row   (o_last_row)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // scale so the largest magnitude sits in [2^30, 2^31), then divide by the length
    function automatic bit unit_vector(input vec3_t v, output vec3_t o);
        logic [63:0] m [3];
        logic [63:0] mx, sum, len, q;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        for (int i = 0; i < 3; i++) o[i] = 0;
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRACTION_BITS) + (len >> 1)) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic longint fixed_round(input longint x);
        logic [63:0] m;
        longint r;
        m = (x < 0) ? 64'(-x) : 64'(x);
        r = longint'((m + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS);
        return (x < 0) ? -r : r;
    endfunction

    function automatic longint clip32(input longint x, inout bit hit);
        if (x > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    task automatic predict_view(input t_data ex, ey, ez, tx, ty, tz, ux, uy, uz);
        vec3_t eye, dir, up, f, cr, s, u;
        longint one;
        bit hit;
        matrix_row_t r;
        one = longint'(1) << FRACTION_BITS;
        hit = 1'b0;
        eye[0] = ex; eye[1] = ey; eye[2] = ez;
        dir[0] = longint'(tx) - ex; dir[1] = longint'(ty) - ey; dir[2] = longint'(tz) - ez;
        up[0] = ux; up[1] = uy; up[2] = uz;
        if (unit_vector(dir, f)) begin
            cr[0] = f[1] * up[2] - f[2] * up[1];
            cr[1] = f[2] * up[0] - f[0] * up[2];
            cr[2] = f[0] * up[1] - f[1] * up[0];
            if (unit_vector(cr, s)) begin
                u[0] = fixed_round(s[1] * f[2] - s[2] * f[1]);
                u[1] = fixed_round(s[2] * f[0] - s[0] * f[2]);
                u[2] = fixed_round(s[0] * f[1] - s[1] * f[0]);
                for (int i = 0; i < 3; i++) begin
                    r.row = 2'(i);
                    r.col[0] = 32'(s[i]);
                    r.col[1] = 32'(u[i]);
                    r.col[2] = 32'(-f[i]);
                    r.col[3] = 32'd0;
                    r.degen = 1'b0;
                    r.sat = 1'b0;
                    r.last = 1'b0;
                    expected_rows.push_back(r);
                end
                r.row = 2'd3;
                r.col[0] = 32'(clip32(-fixed_round(s[0]*eye[0] + s[1]*eye[1] + s[2]*eye[2]), hit));
                r.col[1] = 32'(clip32(-fixed_round(u[0]*eye[0] + u[1]*eye[1] + u[2]*eye[2]), hit));
                r.col[2] = 32'(clip32(fixed_round(f[0]*eye[0] + f[1]*eye[1] + f[2]*eye[2]), hit));
                r.col[3] = 32'(one);
                r.degen = 1'b0;
                r.sat = hit;
                r.last = 1'b1;
                expected_rows.push_back(r);
                return;
            end
        end
        // zero-length direction or cross product: identity
        for (int i = 0; i < 4; i++) begin
            r.row = 2'(i);
            for (int j = 0; j < 4; j++) r.col[j] = (i == j) ? 32'(one) : 32'd0;
            r.degen = 1'b1;
            r.sat = 1'b0;
            r.last = (i == 3);
            expected_rows.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("mismatch at %0t: %s expected %0h got %0h", $time, field, want, got);
        error_count++;
    endtask

    // start stays high across back-to-back items; it is lowered for random idle cycles set by idle_pct
    task automatic send_camera(input t_data ex, ey, ez, tx, ty, tz, ux, uy, uz);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_eye_x <= ex; i_eye_y <= ey; i_eye_z <= ez;
        i_target_x <= tx; i_target_y <= ty; i_target_z <= tz;
        i_upward_x <= ux; i_upward_y <= uy; i_upward_z <= uz;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_view(ex, ey, ez, tx, ty, tz, ux, uy, uz);
    endtask

    always @(posedge i_clk) begin
        matrix_row_t w;
        if (i_rst_n && o_valid) begin
            if (expected_rows.size() == 0) begin
                $display("unexpected row at %0t", $time);
                error_count++;
            end else begin
                w = expected_rows.pop_front();
                if (o_row_index !== w.row) report_mismatch("row_index", w.row, o_row_index);
                if (o_col_0 !== w.col[0]) report_mismatch("col_0", w.col[0], o_col_0);
                if (o_col_1 !== w.col[1]) report_mismatch("col_1", w.col[1], o_col_1);
                if (o_col_2 !== w.col[2]) report_mismatch("col_2", w.col[2], o_col_2);
                if (o_col_3 !== w.col[3]) report_mismatch("col_3", w.col[3], o_col_3);
                if (o_degenerate !== w.degen) report_mismatch("degenerate", w.degen, o_degenerate);
                if (o_saturated !== w.sat) report_mismatch("saturated", w.sat, o_saturated);
                if (o_last_row !== w.last) report_mismatch("last_row", w.last, o_last_row);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("look_at_view_matrix regression: fail");
            $finish;
        end
    end

    function automatic t_data small_val();
        return t_data'($urandom_range(2097152)) - 32'sd1048576;
    endfunction

    task automatic test_directed();
        idle_pct = 0;
        send_camera(0, 0, 0, 0, 0, -ONE, 0, ONE, 0);
        send_camera(ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, ONE, 0);
        // target equal to eye
        send_camera(5*ONE, -ONE, 7, 5*ONE, -ONE, 7, 0, ONE, 0);
        // zero upward
        send_camera(0, 0, 0, ONE, ONE, 0, 0, 0, 0);
        // upward parallel to the view direction
        send_camera(0, 0, 0, 0, 3*ONE, 0, 0, ONE, 0);
        send_camera(ONE, 0, 0, ONE, -5*ONE, 0, 0, -ONE, 0);
        // translations clip high and low
        send_camera(QMAX, QMAX, QMAX, QMAX - ONE, QMAX - ONE, QMAX - ONE, 0, ONE, 0);
        send_camera(QMIN, QMIN, QMIN, QMIN + ONE, QMIN + ONE, QMIN + ONE, 0, ONE, 0);
        send_camera(QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX);
        send_camera(QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN);
        send_camera(-1, -1, -1, 0, 0, 0, -1, 0, 0);
        send_camera(0, 0, 0, 1, 0, 0, 0, 0, 1);
        send_camera(QMAX, 0, 0, QMIN, 0, 0, 0, QMAX, QMIN);
        send_camera(3, -7, 11, -5*ONE, 9*ONE, ONE/2, -ONE, -ONE, ONE);
        send_camera(0, 0, 0, 0, 0, QMIN, QMIN, QMIN, 0);
        send_camera(-ONE, ONE, 0, ONE, -ONE, 0, QMAX, QMAX, QMAX);
        start <= 1'b0;
    endtask

    task automatic test_random(input int items, input int pct);
        t_data e[3], t[3], up[3];
        int kind;
        idle_pct = pct;
        for (int n = 0; n < items; n++) begin
            kind = $urandom_range(9);
            for (int i = 0; i < 3; i++) begin
                if (kind < 3) begin
                    e[i] = $urandom; t[i] = $urandom; up[i] = $urandom;
                end else begin
                    e[i] = small_val(); t[i] = small_val(); up[i] = small_val();
                end
            end
            if (kind == 8) begin
                t = e;
            end else if (kind == 9) begin
                // upward along the view direction
                for (int i = 0; i < 3; i++) up[i] = (t[i] - e[i]) * 2;
            end
            send_camera(e[0], e[1], e[2], t[0], t[1], t[2], up[0], up[1], up[2]);
        end
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        error_count = 0;
        idle_pct = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        {i_eye_x, i_eye_y, i_eye_z} = '0;
        {i_target_x, i_target_y, i_target_z} = '0;
        {i_upward_x, i_upward_y, i_upward_z} = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(65, 0);
        test_random(65, 65);
        test_random(65, 26);
        test_random(65, 0);

        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("look_at_view_matrix regression: pass");
        end else begin
            $display("look_at_view_matrix regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lavm_pkg.sv
hw/rtl/lavm_front.sv
hw/rtl/lavm_norm.sv
hw/rtl/lavm_back.sv
hw/rtl/look_at_view_matrix.sv
tb/sv/tb_look_at_view_matrix.sv
